// ===== hw/rtl/ptab_pkg.sv =====
// shared types and constants of the permutation table engine
package ptab_pkg;

   localparam int PERM_MAX = 256;
   localparam int IDX_W    = $clog2(PERM_MAX);
   localparam int N_W      = $clog2(PERM_MAX + 1);
   localparam int SIZE_W   = 9;
   localparam int RND_W    = 32;
   localparam int STEP_W   = $clog2(RND_W);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   // byte address of the active_size register
   localparam logic [1:0] CSR_ADDR_SIZE = 2'd0;

   localparam logic [2:0] KIND_IDENT = 3'd0;
   localparam logic [2:0] KIND_WRITE = 3'd1;
   localparam logic [2:0] KIND_READ  = 3'd2;
   localparam logic [2:0] KIND_SWAP  = 3'd3;
   localparam logic [2:0] KIND_STEP  = 3'd4;
   localparam logic [2:0] KIND_FIND  = 3'd5;
   localparam logic [2:0] KIND_CHECK = 3'd6;
   localparam logic [2:0] KIND_INV   = 3'd7;

   typedef struct packed {
      logic [2:0]       kind;
      logic [7:0]       index_a;
      logic [7:0]       index_b;
      logic [7:0]       value;
      logic [RND_W-1:0] random_word;
   } req_type;

   typedef struct packed {
      logic [7:0] result_value;
      logic       found;
      logic       valid_res;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [N_W-1:0]   divisor;
   } mod_req_type;

   typedef struct packed {
      logic           done;
      logic [N_W-1:0] remainder;
   } mod_rsp_type;

endpackage

// ===== hw/rtl/ptab_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module ptab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ptab_mod.sv =====
// bit-serial remainder unit for the shuffle step, one dividend bit per cycle
module ptab_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  ptab_pkg::mod_req_type mod_req,
   output ptab_pkg::mod_rsp_type mod_rsp
);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [ptab_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [ptab_pkg::RND_W-1:0]  sh_ff, sh_in;
   logic [ptab_pkg::N_W-1:0]    div_ff, div_in;
   logic [ptab_pkg::N_W-1:0]    rem_ff, rem_in;
   logic [ptab_pkg::N_W:0]      trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, sh_ff[ptab_pkg::RND_W-1]};
      if (mod_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         sh_in  = mod_req.dividend;
         div_in = mod_req.divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[ptab_pkg::N_W-1:0];
         sh_in  = {sh_ff[ptab_pkg::RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ptab_pkg::STEP_W'(ptab_pkg::RND_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/permutation_table_engine.sv =====
// permutation table engine top level: command sequencer around the table rams
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall ptab_pkg::req_type
//  rsp      out        rsp_valid/rsp_stall ptab_pkg::rsp_type
//  csr      in         apb psel/penable    active_size at byte address 0
//
// one command at a time, n = active_size limited to 256: write, read, swap,
// shuffle step (serial remainder), identity, find, check and invert; each
// walk is paced by one ram port.
// after reset a pass over all 256 entries loads the identity, req_stall is high meanwhile.
// a finished result waits in the output register while the next command runs.
module permutation_table_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ptab_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ptab_pkg::rsp_type         rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam logic [4:0] ST_INIT  = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_DISP  = 5'd2;
   localparam logic [4:0] ST_IDENT = 5'd3;
   localparam logic [4:0] ST_RDW   = 5'd4;
   localparam logic [4:0] ST_MOD   = 5'd5;
   localparam logic [4:0] ST_SWA   = 5'd6;
   localparam logic [4:0] ST_SWB   = 5'd7;
   localparam logic [4:0] ST_SWC   = 5'd8;
   localparam logic [4:0] ST_FIND  = 5'd9;
   localparam logic [4:0] ST_CLR   = 5'd10;
   localparam logic [4:0] ST_CK2   = 5'd11;
   localparam logic [4:0] ST_CK3   = 5'd12;
   localparam logic [4:0] ST_CKEND = 5'd13;
   localparam logic [4:0] ST_INV   = 5'd14;
   localparam logic [4:0] ST_CPY   = 5'd15;
   localparam logic [4:0] ST_DONE  = 5'd16;

   localparam int IW = ptab_pkg::IDX_W;
   localparam int NW = ptab_pkg::N_W;

   logic [4:0]                    state_ff, state_in;
   ptab_pkg::req_type             item_ff, item_in;
   ptab_pkg::rsp_type             build_ff, build_in;
   ptab_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ptab_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [NW-1:0]                 n_ff, n_in;
   logic [NW-1:0]                 k_ff, k_in;
   logic                          pv_ff, pv_in;
   logic [IW-1:0]                 pk_ff, pk_in;
   logic [7:0]                    tmp_ff, tmp_in;
   logic                          ok_ff, ok_in;
   logic [NW-1:0]                 n_cur;
   logic                          csr_write;

   logic          ent_we, scr_we, seen_we;
   logic [IW-1:0] ent_wa, ent_ra, scr_wa, scr_ra, seen_wa, seen_ra;
   logic [7:0]    ent_wd, ent_rd, scr_wd, scr_rd;
   logic [0:0]    seen_wd, seen_rd;

   ptab_pkg::mod_req_type mod_req;
   ptab_pkg::mod_rsp_type mod_rsp;

   ptab_ram #(.WIDTH(8), .DEPTH(ptab_pkg::PERM_MAX)) u_entries (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(ent_ra), .rd_data(ent_rd)
   );

   ptab_ram #(.WIDTH(8), .DEPTH(ptab_pkg::PERM_MAX)) u_scratch (
      .clock(clock), .wr_en(scr_we), .wr_addr(scr_wa), .wr_data(scr_wd),
      .rd_addr(scr_ra), .rd_data(scr_rd)
   );

   ptab_ram #(.WIDTH(1), .DEPTH(ptab_pkg::PERM_MAX)) u_seen (
      .clock(clock), .wr_en(seen_we), .wr_addr(seen_wa), .wr_data(seen_wd),
      .rd_addr(seen_ra), .rd_data(seen_rd)
   );

   ptab_mod u_mod (
      .clock(clock), .reset(reset), .mod_req(mod_req), .mod_rsp(mod_rsp)
   );

   assign csr_write  = csr_psel & csr_penable & csr_pwrite
                       & (csr_paddr == ptab_pkg::CSR_ADDR_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32 - ptab_pkg::SIZE_W){1'b0}}, size_ff};
   assign size_in    = csr_write ? csr_pwdata[ptab_pkg::SIZE_W-1:0] : size_ff;
   assign n_cur      = (size_ff > ptab_pkg::SIZE_W'(ptab_pkg::PERM_MAX))
                       ? NW'(ptab_pkg::PERM_MAX) : NW'(size_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      build_in     = build_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      n_in         = n_ff;
      k_in         = k_ff;
      pv_in        = pv_ff;
      pk_in        = pk_ff;
      tmp_in       = tmp_ff;
      ok_in        = ok_ff;
      ent_we       = 1'b0;
      ent_wa       = k_ff[IW-1:0];
      ent_wd       = k_ff[7:0];
      ent_ra       = k_ff[IW-1:0];
      scr_we       = 1'b0;
      scr_wa       = ent_rd[IW-1:0];
      scr_wd       = pk_ff[7:0];
      scr_ra       = k_ff[IW-1:0];
      seen_we      = 1'b0;
      seen_wa      = k_ff[IW-1:0];
      seen_wd      = 1'b0;
      seen_ra      = ent_rd[IW-1:0];
      mod_req.start    = 1'b0;
      mod_req.dividend = item_ff.random_word;
      mod_req.divisor  = NW'(item_ff.index_a) + 1'b1;

      case (state_ff)
         ST_INIT: begin
            ent_we = 1'b1;
            k_in   = k_ff + 1'b1;
            if (k_ff == NW'(ptab_pkg::PERM_MAX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               n_in     = n_cur;
               build_in = '0;
               k_in     = '0;
               pv_in    = 1'b0;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (item_ff.kind)
               ptab_pkg::KIND_IDENT: state_in = ST_IDENT;
               ptab_pkg::KIND_WRITE: begin
                  if (NW'(item_ff.index_a) >= n_ff || NW'(item_ff.value) >= n_ff) begin
                     build_in.error = 1'b1;
                  end else begin
                     ent_we = 1'b1;
                     ent_wa = IW'(item_ff.index_a);
                     ent_wd = item_ff.value;
                  end
                  state_in = ST_DONE;
               end
               ptab_pkg::KIND_READ: begin
                  ent_ra = IW'(item_ff.index_a);
                  if (NW'(item_ff.index_a) >= n_ff) begin
                     build_in.error = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_RDW;
                  end
               end
               ptab_pkg::KIND_SWAP: begin
                  ent_ra = IW'(item_ff.index_a);
                  if (NW'(item_ff.index_a) >= n_ff || NW'(item_ff.index_b) >= n_ff) begin
                     build_in.error = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_SWA;
                  end
               end
               ptab_pkg::KIND_STEP: begin
                  if (NW'(item_ff.index_a) >= n_ff) begin
                     build_in.error = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     mod_req.start = 1'b1;
                     state_in      = ST_MOD;
                  end
               end
               ptab_pkg::KIND_FIND: begin
                  if (NW'(item_ff.value) >= n_ff) begin
                     build_in.error = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_FIND;
                  end
               end
               default: state_in = ST_CLR;
            endcase
         end
         ST_IDENT: begin
            if (k_ff < n_ff) begin
               ent_we = 1'b1;
               k_in   = k_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RDW: begin
            build_in.result_value = ent_rd;
            state_in              = ST_DONE;
         end
         ST_MOD: begin
            ent_ra = IW'(item_ff.index_a);
            if (mod_rsp.done) begin
               item_in.index_b = mod_rsp.remainder[7:0];
               state_in        = ST_SWA;
            end
         end
         ST_SWA: begin
            ent_ra   = IW'(item_ff.index_b);
            tmp_in   = ent_rd;
            state_in = ST_SWB;
         end
         ST_SWB: begin
            ent_we   = 1'b1;
            ent_wa   = IW'(item_ff.index_a);
            ent_wd   = ent_rd;
            state_in = ST_SWC;
         end
         ST_SWC: begin
            ent_we   = 1'b1;
            ent_wa   = IW'(item_ff.index_b);
            ent_wd   = tmp_ff;
            state_in = ST_DONE;
         end
         ST_FIND: begin
            // read entry k while comparing the entry read last cycle
            pv_in = (k_ff < n_ff);
            pk_in = k_ff[IW-1:0];
            if (k_ff < n_ff) begin
               k_in = k_ff + 1'b1;
            end
            if (pv_ff && ent_rd == item_ff.value) begin
               build_in.found        = 1'b1;
               build_in.result_value = pk_ff[7:0];
               state_in              = ST_DONE;
            end else if (!pv_ff && k_ff >= n_ff) begin
               build_in.error = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_CLR: begin
            if (k_ff < n_ff) begin
               seen_we = 1'b1;
               k_in    = k_ff + 1'b1;
            end else if (n_ff == '0) begin
               ok_in    = 1'b0;
               state_in = ST_CKEND;
            end else begin
               ent_ra   = '0;
               k_in     = NW'(1);
               state_in = ST_CK2;
            end
         end
         ST_CK2: begin
            tmp_in = ent_rd;
            if (NW'(ent_rd) >= n_ff) begin
               ok_in    = 1'b0;
               state_in = ST_CKEND;
            end else begin
               state_in = ST_CK3;
            end
         end
         ST_CK3: begin
            if (seen_rd[0]) begin
               ok_in    = 1'b0;
               state_in = ST_CKEND;
            end else begin
               seen_we = 1'b1;
               seen_wa = IW'(tmp_ff);
               seen_wd = 1'b1;
               if (k_ff < n_ff) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_CK2;
               end else begin
                  ok_in    = 1'b1;
                  state_in = ST_CKEND;
               end
            end
         end
         ST_CKEND: begin
            k_in  = '0;
            pv_in = 1'b0;
            if (item_ff.kind == ptab_pkg::KIND_CHECK) begin
               build_in.valid_res = ok_ff;
               state_in           = ST_DONE;
            end else if (!ok_ff) begin
               build_in.error = 1'b1;
               state_in       = ST_DONE;
            end else begin
               build_in.valid_res = 1'b1;
               state_in           = ST_INV;
            end
         end
         ST_INV: begin
            // scratch[entries[k]] = k, one entry a cycle
            pv_in = (k_ff < n_ff);
            pk_in = k_ff[IW-1:0];
            if (k_ff < n_ff) begin
               k_in = k_ff + 1'b1;
            end
            scr_we = pv_ff;
            if (!pv_ff && k_ff >= n_ff) begin
               k_in     = '0;
               state_in = ST_CPY;
            end
         end
         ST_CPY: begin
            pv_in = (k_ff < n_ff);
            pk_in = k_ff[IW-1:0];
            if (k_ff < n_ff) begin
               k_in = k_ff + 1'b1;
            end
            ent_we = pv_ff;
            ent_wa = pk_ff;
            ent_wd = scr_rd;
            if (!pv_ff && k_ff >= n_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = build_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         size_ff      <= ptab_pkg::SIZE_RESET;
         k_ff         <= '0;
         pv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
         k_ff         <= k_in;
         pv_ff        <= pv_in;
      end
      item_ff  <= item_in;
      build_ff <= build_in;
      rsp_ff   <= rsp_in;
      n_ff     <= n_in;
      pk_ff    <= pk_in;
      tmp_ff   <= tmp_in;
      ok_ff    <= ok_in;
   end

   a_init_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> req_stall)
      else $error("input taken during identity load");

   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.error))
      else $error("found and error both set");

   a_valid_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.valid_res && rsp_ff.error))
      else $error("valid_res and error both set");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && mod_rsp.done) |-> NW'(mod_rsp.remainder) <= NW'(item_ff.index_a))
      else $error("shuffle remainder out of range");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the permutation table engine
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   ptab_pkg::req_type req_data;
   ptab_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   permutation_table_engine dut (.*);

   // model state
   logic [7:0] perm_tab [ptab_pkg::PERM_MAX];
   logic [7:0] inv_tab [ptab_pkg::PERM_MAX];
   logic [8:0] size_reg;
   ptab_pkg::rsp_type answer_q [$];

   int mismatches, transfers_in, transfers_out, idle_cycles, errors_seen;
   bit calm;

   function automatic bit perm_ok(int n);
      bit seen [ptab_pkg::PERM_MAX];
      bit ok;
      ok = (n != 0);
      for (int k = 0; k < ptab_pkg::PERM_MAX; k++) seen[k] = 0;
      for (int k = 0; k < n; k++) begin
         if (perm_tab[k] >= n || seen[perm_tab[k]]) ok = 0;
         else seen[perm_tab[k]] = 1;
      end
      for (int k = 0; k < n; k++) if (!seen[k]) ok = 0;
      return ok;
   endfunction

   function automatic ptab_pkg::rsp_type apply_command(ptab_pkg::req_type r);
      ptab_pkg::rsp_type o;
      int n, k, j;
      logic [7:0] t;
      o = '0;
      n = (int'(size_reg) > ptab_pkg::PERM_MAX) ? ptab_pkg::PERM_MAX : int'(size_reg);
      case (r.kind)
         ptab_pkg::KIND_IDENT: for (k = 0; k < n; k++) perm_tab[k] = 8'(k);
         ptab_pkg::KIND_WRITE: if (r.index_a >= n || r.value >= n) o.error = 1;
                     else perm_tab[r.index_a] = r.value;
         ptab_pkg::KIND_READ: if (r.index_a >= n) o.error = 1;
                    else o.result_value = perm_tab[r.index_a];
         ptab_pkg::KIND_SWAP, ptab_pkg::KIND_STEP: begin
            j = (r.kind == ptab_pkg::KIND_SWAP) ? int'(r.index_b)
                : int'(r.random_word % (32'(r.index_a) + 32'd1));
            if (r.index_a >= n || j >= n) o.error = 1;
            else begin
               t = perm_tab[r.index_a];
               perm_tab[r.index_a] = perm_tab[j];
               perm_tab[j] = t;
            end
         end
         ptab_pkg::KIND_FIND: begin
            o.error = 1;
            if (r.value < n)
               for (k = n - 1; k >= 0; k--)
                  if (perm_tab[k] == r.value) begin
                     o.found = 1; o.error = 0; o.result_value = 8'(k);
                  end
         end
         ptab_pkg::KIND_CHECK: o.valid_res = perm_ok(n);
         default: if (perm_ok(n)) begin
            o.valid_res = 1;
            for (k = 0; k < n; k++) inv_tab[perm_tab[k]] = 8'(k);
            for (k = 0; k < n; k++) perm_tab[k] = inv_tab[k];
         end else o.error = 1;
      endcase
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: longest wait is an invert plus stalls
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // result side: stall at random, compare each transfer
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            transfers_out++;
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               ptab_pkg::rsp_type e;
               e = answer_q.pop_front();
               if (rsp_data.error) errors_seen++;
               if (rsp_data.result_value !== e.result_value || rsp_data.found !== e.found
                   || rsp_data.valid_res !== e.valid_res || rsp_data.error !== e.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at result %0d: expected %p got %p",
                              transfers_out, e, rsp_data);
               end
            end
         end
         @(negedge clock);
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
      end
   end

   task automatic csr_write(logic [8:0] v);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= ptab_pkg::CSR_ADDR_SIZE; csr_pwdata <= 32'(v);
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      size_reg = v;
   endtask

   // drives one transfer; the caller is at a falling edge
   task automatic send(ptab_pkg::req_type r, bit typed, ptab_pkg::rsp_type want);
      ptab_pkg::rsp_type got;
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      got = apply_command(r);
      if (typed && got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("typed answer %p disagrees with %p", want, got);
      end
      answer_q.push_back(got);
      transfers_in++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (answer_q.size() != 0) @(negedge clock);
      repeat (1400) @(negedge clock);
   endtask

   function automatic ptab_pkg::req_type mk(logic [2:0] k, int a, int b, int v,
                                            logic [31:0] w);
      ptab_pkg::req_type r;
      r.kind = k; r.index_a = 8'(a); r.index_b = 8'(b); r.value = 8'(v);
      r.random_word = w;
      return r;
   endfunction

   function automatic ptab_pkg::rsp_type ans(int rv, bit f, bit vr, bit er);
      ptab_pkg::rsp_type o;
      o.result_value = 8'(rv); o.found = f; o.valid_res = vr; o.error = er;
      return o;
   endfunction

   typedef struct {
      ptab_pkg::req_type cmd;
      bit typed;
      ptab_pkg::rsp_type want;
   } row_type;

   row_type plan [$];
   int sizes [6] = '{16, 256, 1, 0, 300, 511};
   int n;
   ptab_pkg::req_type r;

   initial begin
      reset = 1; req_valid = 0; req_data = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      calm = 0; mismatches = 0; transfers_in = 0; transfers_out = 0; idle_cycles = 0;
      errors_seen = 0; size_reg = ptab_pkg::SIZE_RESET;
      for (int k = 0; k < ptab_pkg::PERM_MAX; k++) perm_tab[k] = 8'(k);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table at reset size 16
      plan = '{
         '{mk(ptab_pkg::KIND_READ, 15, 0, 0, 0), 1, ans(15, 0, 0, 0)},
         '{mk(ptab_pkg::KIND_READ, 16, 0, 0, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_READ, 255, 0, 0, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_CHECK, 0, 0, 0, 0), 1, ans(0, 0, 1, 0)},
         '{mk(ptab_pkg::KIND_FIND, 0, 0, 15, 0), 1, ans(15, 1, 0, 0)},
         '{mk(ptab_pkg::KIND_FIND, 0, 0, 16, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_WRITE, 16, 0, 1, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_WRITE, 0, 0, 255, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_SWAP, 0, 15, 0, 0), 1, ans(0, 0, 0, 0)},
         '{mk(ptab_pkg::KIND_SWAP, 3, 200, 0, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_STEP, 15, 0, 0, 32'hFFFF_FFFF), 0, '0},
         '{mk(ptab_pkg::KIND_STEP, 0, 0, 0, 32'h1234_5678), 0, '0},
         '{mk(ptab_pkg::KIND_STEP, 16, 0, 0, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_INV, 0, 0, 0, 0), 1, ans(0, 0, 1, 0)},
         '{mk(ptab_pkg::KIND_WRITE, 2, 0, 5, 0), 1, ans(0, 0, 0, 0)},
         '{mk(ptab_pkg::KIND_FIND, 0, 0, 5, 0), 0, '0},
         '{mk(ptab_pkg::KIND_CHECK, 0, 0, 0, 0), 1, ans(0, 0, 0, 0)},
         '{mk(ptab_pkg::KIND_INV, 0, 0, 0, 0), 1, ans(0, 0, 0, 1)},
         '{mk(ptab_pkg::KIND_IDENT, 0, 0, 0, 0), 1, ans(0, 0, 0, 0)},
         '{mk(ptab_pkg::KIND_INV, 0, 0, 0, 0), 1, ans(0, 0, 1, 0)}
      };
      foreach (plan[i]) send(plan[i].cmd, plan[i].typed, plan[i].want);
      drain();

      // random phases over several sizes, mostly valid indexes, with extra shuffles
      foreach (sizes[s]) begin
         csr_write(9'(sizes[s]));
         n = (sizes[s] > ptab_pkg::PERM_MAX) ? ptab_pkg::PERM_MAX : sizes[s];
         calm = (s == 2);
         for (int i = 0; i < ((n > 64) ? 140 : 240); i++) begin
            r.kind = 3'($urandom_range(7));
            r.index_b = 8'($urandom_range(255));
            r.value = 8'($urandom_range(255));
            r.random_word = $urandom;
            r.index_a = 8'($urandom_range(255));
            if (n > 0 && $urandom_range(99) < 80) begin
               r.index_a = 8'($urandom_range(n - 1));
               r.index_b = 8'($urandom_range(n - 1));
               r.value = 8'($urandom_range(n - 1));
               if ($urandom_range(99) < 30) r.kind = ptab_pkg::KIND_STEP;
               if ($urandom_range(99) < 8) r.kind = ptab_pkg::KIND_IDENT;
            end
            send(r, 0, '0);
         end
         drain();
      end

      $display("%0d commands over six table sizes incl. 0, 1, 256 and above",
               transfers_in);
      $display("%0d results checked, %0d of them errors", transfers_out, errors_seen);
      if (mismatches == 0 && answer_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== permutation_table_engine.f =====
hw/rtl/ptab_pkg.sv
hw/rtl/ptab_ram.sv
hw/rtl/ptab_mod.sv
hw/rtl/permutation_table_engine.sv
verif/testbench.sv
